// File: hdl/ndf_pkg.sv
// Shared types and constants of the netstring deframer.
// No dependencies; the other design files of the block, apart from ndf_if.sv, refer to this package.
package ndf_pkg;

	// Width and reset value of the payload limit register
	localparam int unsigned CFG_W = 13;
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	// Default compile-time ceiling on the payload length
	localparam int unsigned DEFAULT_MAX_PAYLOAD = 4096;

	// Characters of the framing
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	// Frame status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BADLEN  = 3'd1,
		ST_ZERO    = 3'd2,
		ST_OVER    = 3'd3,
		ST_NOCOMMA = 3'd4
	} status_t;

	// One result beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
		status_t    status;
	} res_t;

endpackage

// File: hdl/ndf_if.sv
// Valid/ready channels of the netstring deframer: byte stream in, results out.
// No dependencies.
interface ndf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface ndf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;
	logic [2:0] status;

	modport source (output valid, output data_byte, output frame_end, output status,
		input ready);
	modport sink (input valid, input data_byte, input frame_end, input status,
		output ready);
endinterface

// File: hdl/netstring_deframer_unit.sv
// Top level of the netstring deframer: limit register, step core, result register.
// Depends on ndf_pkg, ndf_in_if, ndf_out_if and ndf_core.
//
// Usage:
//   stream carries one byte of the serial netstring stream per beat
//   (<decimal length> ':' <payload> ','). result gives at most one beat per
//   input byte: a payload byte (frame_end low, status ok) or a frame end
//   (frame_end high, data_byte zero, status ok or an error code).
//   cfg_we / cfg_wdata load the payload limit; write it only while idle.
//   The limit in force is the smaller of that value and MAX_PAYLOAD.
//   Throughput: one byte per cycle unless the result register stalls.
//   A result is valid in the cycle after its byte is accepted; the step
//   logic sits between the frame state and a single result register.
//   Stalls: the result register holds its beat while result.ready is low;
//   stream.ready stays high while that register is empty or being drained in
//   the same cycle, so a stalled receiver holds back at most one byte.
//   Reset: arst_n clears the frame state (start of a length field), empties
//   the result register and sets the limit to 4096.
//   After an error a frame end with its status is sent; unless the bad byte
//   was itself a comma, bytes are dropped up to and including the next comma.
module netstring_deframer_unit #(
	parameter int unsigned MAX_PAYLOAD = ndf_pkg::DEFAULT_MAX_PAYLOAD
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ndf_in_if.sink                    stream,
	ndf_out_if.source                 result,
	input  logic                      cfg_we,
	input  logic [ndf_pkg::CFG_W-1:0] cfg_wdata
);

	logic [ndf_pkg::CFG_W-1:0] limit_q;
	logic                      in_ready;
	logic                      accept;
	logic                      core_valid;
	ndf_pkg::res_t             core_res;
	logic                      out_valid_q;
	ndf_pkg::res_t             out_res_q;

	// Take a new byte when the result register is free or draining
	assign in_ready     = !out_valid_q || result.ready;
	assign stream.ready = in_ready;
	assign accept       = stream.valid && in_ready;

	// Hold the payload limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ndf_pkg::CFG_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	ndf_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (stream.in_byte),
		.limit_cfg(limit_q),
		.res_valid(core_valid),
		.res      (core_res)
	);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept && core_valid;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_res_q <= core_res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.data_byte = out_res_q.data_byte;
	assign result.frame_end = out_res_q.frame_end;
	assign result.status    = out_res_q.status;

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.frame_end) |-> result.status == ndf_pkg::ST_OK)
		else $error("payload beat with nonzero status");

	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_end) |-> result.data_byte == 8'h00)
		else $error("frame end beat with data");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !accept)
		else $error("byte accepted while result register is stalled");

endmodule

// File: hdl/ndf_core.sv
// Frame state of the netstring deframer and the per-byte step logic.
// Depends on ndf_pkg.
module ndf_core #(
	parameter int unsigned MAX_PAYLOAD = ndf_pkg::DEFAULT_MAX_PAYLOAD
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               in_byte,
	input  logic [ndf_pkg::CFG_W-1:0] limit_cfg,
	output logic                     res_valid,
	output ndf_pkg::res_t            res
);

	// Accumulator holds up to MAX_PAYLOAD + 1 (saturation point)
	localparam int unsigned LW = $clog2(MAX_PAYLOAD + 2);
	localparam int unsigned CW = (LW > ndf_pkg::CFG_W) ? LW : ndf_pkg::CFG_W;
	localparam logic [LW-1:0] SAT = LW'(MAX_PAYLOAD + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_LEN   = 4'b0001,
		PH_DATA  = 4'b0010,
		PH_COMMA = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [LW-1:0] acc_q, acc_n;
	logic          dig_q, dig_n;
	logic [LW-1:0] rem_q, rem_n;

	logic [CW-1:0]   cfg_ext;
	logic [CW-1:0]   limit;
	logic [CW-1:0]   acc_ext;
	logic            is_digit;
	logic [LW+3:0]   acc_mul;
	logic [LW-1:0]   acc_sat;

	// Cap the configured limit at the compile-time ceiling
	assign cfg_ext = CW'(limit_cfg);
	assign limit   = (cfg_ext > CAP) ? CAP : cfg_ext;
	assign acc_ext = CW'(acc_q);

	// Next length value: acc * 10 + digit, saturated
	assign is_digit = (in_byte >= ndf_pkg::CH_ZERO) && (in_byte <= ndf_pkg::CH_NINE);
	assign acc_mul  = ((LW+4)'(acc_q) << 3) + ((LW+4)'(acc_q) << 1)
		+ (LW+4)'(in_byte[3:0]);
	assign acc_sat  = (acc_mul > (LW+4)'(SAT)) ? SAT : acc_mul[LW-1:0];

	// Step one byte through the frame state
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		dig_n     = dig_q;
		rem_n     = rem_q;
		res_valid = 1'b0;
		res       = '{data_byte: 8'h00, frame_end: 1'b1, status: ndf_pkg::ST_OK};
		unique case (phase_q)
			PH_LEN: begin
				if (is_digit) begin
					acc_n = acc_sat;
					dig_n = 1'b1;
				end else if (in_byte == ndf_pkg::CH_COLON) begin
					if (!dig_q) begin
						phase_n    = PH_SKIP;
						res_valid  = 1'b1;
						res.status = ndf_pkg::ST_BADLEN;
					end else if (acc_q == '0) begin
						phase_n    = PH_SKIP;
						res_valid  = 1'b1;
						res.status = ndf_pkg::ST_ZERO;
					end else if (acc_ext > limit) begin
						phase_n    = PH_SKIP;
						res_valid  = 1'b1;
						res.status = ndf_pkg::ST_OVER;
					end else begin
						rem_n   = acc_q;
						phase_n = PH_DATA;
					end
				end else begin
					// Any other byte is a bad length; a comma restarts right away
					res_valid  = 1'b1;
					res.status = ndf_pkg::ST_BADLEN;
					if (in_byte == ndf_pkg::CH_COMMA) begin
						phase_n = PH_LEN;
						acc_n   = '0;
						dig_n   = 1'b0;
						rem_n   = '0;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_DATA: begin
				res_valid     = 1'b1;
				res.data_byte = in_byte;
				res.frame_end = 1'b0;
				rem_n         = rem_q - LW'(1);
				if (rem_q == LW'(1)) begin
					phase_n = PH_COMMA;
				end
			end
			PH_COMMA: begin
				res_valid = 1'b1;
				if (in_byte == ndf_pkg::CH_COMMA) begin
					phase_n = PH_LEN;
					acc_n   = '0;
					dig_n   = 1'b0;
					rem_n   = '0;
				end else begin
					phase_n    = PH_SKIP;
					res.status = ndf_pkg::ST_NOCOMMA;
				end
			end
			PH_SKIP: begin
				// Drop bytes up to and including the next comma
				if (in_byte == ndf_pkg::CH_COMMA) begin
					phase_n = PH_LEN;
					acc_n   = '0;
					dig_n   = 1'b0;
					rem_n   = '0;
				end
			end
			default: begin
				phase_n = PH_LEN;
				acc_n   = '0;
				dig_n   = 1'b0;
				rem_n   = '0;
			end
		endcase
	end

	// Advance the frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			acc_q   <= '0;
			dig_q   <= 1'b0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			dig_q   <= dig_n;
			rem_q   <= rem_n;
		end
	end

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= SAT)
		else $error("length accumulator beyond saturation");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("payload phase with no bytes left");

	a_fresh_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEN && !dig_q) |-> acc_q == '0)
		else $error("new frame with stale length");

endmodule
